### sv/lacb_pkg.sv
// lacb_pkg: shared widths for the look-at camera basis pipeline
// used by lacb_sqrt, lacb_div and lacb_norm; no dependencies
package lacb_pkg;

  // normalized magnitude: largest component lands in [2^29, 2^30)
  localparam int MAG_W    = 30;
  localparam int NORM_MSB = MAG_W - 1;

  // sum of three squared magnitudes and its integer square root
  localparam int RAD_W  = 2 * MAG_W + 2;
  localparam int ROOT_W = MAG_W + 1;

endpackage

### sv/lacb_sqrt.sv
// lacb_sqrt: pipelined integer square root, one root bit per stage
// depends on lacb_pkg for the radicand and root widths
module lacb_sqrt #(
  parameter int SW = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [lacb_pkg::RAD_W-1:0]   rad_i,
  input  logic [SW-1:0]                side_i,
  output logic                         valid_o,
  output logic [lacb_pkg::ROOT_W-1:0]  root_o,
  output logic [SW-1:0]                side_o
);

  localparam int N  = lacb_pkg::ROOT_W;
  localparam int RW = lacb_pkg::RAD_W;
  localparam int TW = RW + 2;

  logic          vld_q  [N];
  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];
  logic [SW-1:0] side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic          v_in;
    logic [RW-1:0] rem_in;
    logic [N-1:0]  root_in;
    logic [SW-1:0] s_in;
    logic [TW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign s_in    = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = side_q[k-1];
    end

    // (q + 2^B)^2 - q^2 = q * 2^(B+1) + 2^(2B)
    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(rem_in) >= trial;

    // valid travels with the data
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    // trial subtract for this root bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? rem_in - trial[RW-1:0] : rem_in;
        root_q[k] <= take ? (root_in | (N'(1) << B)) : root_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

### sv/lacb_div.sv
// lacb_div: three-lane pipelined restoring divider sharing one divisor
// depends on lacb_pkg for the divisor width
module lacb_div #(
  parameter int F  = 16,
  parameter int SW = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [lacb_pkg::ROOT_W-1:0]        den_i,
  input  logic [2:0][lacb_pkg::ROOT_W+F-1:0] num_i,
  input  logic [SW-1:0]                      side_i,
  output logic                               valid_o,
  output logic [2:0][F:0]                    quo_o,
  output logic [SW-1:0]                      side_o
);

  localparam int N  = F + 1;
  localparam int NW = lacb_pkg::ROOT_W + F;

  logic                         vld_q  [N];
  logic [lacb_pkg::ROOT_W-1:0]  den_q  [N];
  logic [2:0][NW-1:0]           rem_q  [N];
  logic [2:0][N-1:0]            quo_q  [N];
  logic [SW-1:0]                side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic                        v_in;
    logic [lacb_pkg::ROOT_W-1:0] d_in;
    logic [2:0][NW-1:0]          rem_in;
    logic [2:0][N-1:0]           quo_in;
    logic [SW-1:0]               s_in;
    logic [NW-1:0]               trial;
    logic [2:0][NW-1:0]          rem_d;
    logic [2:0][N-1:0]           quo_d;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign d_in   = den_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = vld_q[k-1];
      assign d_in   = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign s_in   = side_q[k-1];
    end

    assign trial = NW'(d_in) << B;

    // one quotient bit per lane
    for (genvar j = 0; j < 3; j++) begin : g_lane
      always_comb begin
        if (rem_in[j] >= trial) begin
          rem_d[j] = rem_in[j] - trial;
          quo_d[j] = quo_in[j] | (N'(1) << B);
        end else begin
          rem_d[j] = rem_in[j];
          quo_d[j] = quo_in[j];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= d_in;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

### sv/lacb_cross.sv
// lacb_cross: two-stage exact cross product a x b of signed vectors
// no package dependencies
module lacb_cross #(
  parameter int AW = 32,
  parameter int BW = 18,
  parameter int SW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2:0][AW-1:0]        a_i,
  input  logic [2:0][BW-1:0]        b_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [2:0][AW+BW:0]       c_o,
  output logic [SW-1:0]             side_o
);

  localparam int PW = AW + BW;

  logic                       vld1_q, vld2_q;
  logic signed [PW-1:0]       pa_q [3];
  logic signed [PW-1:0]       pb_q [3];
  logic [2:0][PW:0]           c_q;
  logic [SW-1:0]              side1_q, side2_q;

  for (genvar j = 0; j < 3; j++) begin : g_comp
    localparam int J1 = (j + 1) % 3;
    localparam int J2 = (j + 2) % 3;
    logic signed [AW-1:0] x1, x2;
    logic signed [BW-1:0] y1, y2;
    logic signed [PW-1:0] pa_d, pb_d;
    logic signed [PW:0]   c_d;

    assign x1   = a_i[J1];
    assign x2   = a_i[J2];
    assign y1   = b_i[J1];
    assign y2   = b_i[J2];
    assign pa_d = x1 * y2;
    assign pb_d = x2 * y1;
    assign c_d  = pa_q[j] - pb_q[j];

    // products, then their difference
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[j] <= pa_d;
        pb_q[j] <= pb_d;
        c_q[j]  <= c_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
    end
  end

  assign valid_o = vld2_q;
  assign c_o     = c_q;
  assign side_o  = side2_q;

endmodule

### sv/lacb_norm.sv
// lacb_norm: pipelined vector normalize to signed Q1.F with zero detect
// depends on lacb_pkg, lacb_sqrt and lacb_div
module lacb_norm #(
  parameter int IW = 33,
  parameter int F  = 16,
  parameter int SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][IW-1:0]  vec_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [2:0][F+1:0]   vec_o,
  output logic                ok_o,
  output logic [SW-1:0]       side_o
);

  localparam int MW  = lacb_pkg::MAG_W;
  localparam int RTW = lacb_pkg::ROOT_W;
  localparam int NW  = RTW + F;
  localparam int PW  = $clog2(IW);
  localparam int XW  = IW + lacb_pkg::NORM_MSB;
  localparam int QSW = 3 * MW + 4 + SW;
  localparam int DSW = 4 + SW;

  // stage 1: magnitudes and signs
  logic              v1_q;
  logic [2:0][IW-1:0] m1_q;
  logic [2:0]        s1_q;
  logic [SW-1:0]     sd1_q;
  logic [2:0][IW-1:0] m1_d;

  for (genvar j = 0; j < 3; j++) begin : g_mag
    assign m1_d[j] = vec_i[j][IW-1] ? IW'(-vec_i[j]) : vec_i[j];
  end

  // stage 2: leading one of the largest magnitude
  logic              v2_q;
  logic [2:0][IW-1:0] m2_q;
  logic [2:0]        s2_q;
  logic              nz2_q;
  logic [PW-1:0]     pos2_q;
  logic [SW-1:0]     sd2_q;
  logic [IW-1:0]     orv;
  logic [PW-1:0]     pos_d;

  assign orv = m1_q[0] | m1_q[1] | m1_q[2];

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < IW; i++) begin
      if (orv[i]) begin
        pos_d = PW'(i);
      end
    end
  end

  // stage 3: common shift so the largest top bit sits at NORM_MSB
  logic              v3_q;
  logic [2:0][MW-1:0] m3_q;
  logic [2:0]        s3_q;
  logic              nz3_q;
  logic [SW-1:0]     sd3_q;
  logic [2:0][MW-1:0] m3_d;

  for (genvar j = 0; j < 3; j++) begin : g_shift
    logic [XW-1:0] ext;
    assign ext     = {m2_q[j], {lacb_pkg::NORM_MSB{1'b0}}} >> pos2_q;
    assign m3_d[j] = ext[MW-1:0];
  end

  // stage 4: squares
  logic              v4_q;
  logic [2:0][MW-1:0] m4_q;
  logic [2:0][2*MW-1:0] sq4_q;
  logic [2:0]        s4_q;
  logic              nz4_q;
  logic [SW-1:0]     sd4_q;

  // stage 5: sum of squares
  logic                        v5_q;
  logic [lacb_pkg::RAD_W-1:0]  sum5_q;
  logic [QSW-1:0]              sd5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= m1_d;
      s1_q   <= {vec_i[2][IW-1], vec_i[1][IW-1], vec_i[0][IW-1]};
      sd1_q  <= side_i;
      m2_q   <= m1_q;
      s2_q   <= s1_q;
      nz2_q  <= |orv;
      pos2_q <= pos_d;
      sd2_q  <= sd1_q;
      m3_q   <= m3_d;
      s3_q   <= s2_q;
      nz3_q  <= nz2_q;
      sd3_q  <= sd2_q;
      m4_q   <= m3_q;
      for (int j = 0; j < 3; j++) begin
        sq4_q[j] <= m3_q[j] * m3_q[j];
      end
      s4_q   <= s3_q;
      nz4_q  <= nz3_q;
      sd4_q  <= sd3_q;
      sum5_q <= lacb_pkg::RAD_W'(sq4_q[0]) + lacb_pkg::RAD_W'(sq4_q[1])
              + lacb_pkg::RAD_W'(sq4_q[2]);
      sd5_q  <= {m4_q, s4_q, nz4_q, sd4_q};
    end
  end

  // length
  logic              vq;
  logic [RTW-1:0]    len;
  logic [QSW-1:0]    sdq;

  lacb_sqrt #(.SW(QSW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v5_q),
    .rad_i   (sum5_q),
    .side_i  (sd5_q),
    .valid_o (vq),
    .root_o  (len),
    .side_o  (sdq)
  );

  // rounded numerators for the divide
  logic              vp_q;
  logic [RTW-1:0]    lenp_q;
  logic [2:0][NW-1:0] nump_q;
  logic [DSW-1:0]    sdp_q;
  logic [2:0][MW-1:0] mq;

  assign mq = sdq[QSW-1 -: 3 * MW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lenp_q <= len;
      for (int j = 0; j < 3; j++) begin
        nump_q[j] <= (NW'(mq[j]) << F) + NW'(len >> 1);
      end
      sdp_q <= sdq[DSW-1:0];
    end
  end

  logic              vd;
  logic [2:0][F:0]   quo;
  logic [DSW-1:0]    sdd;

  lacb_div #(.F(F), .SW(DSW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vp_q),
    .den_i   (lenp_q),
    .num_i   (nump_q),
    .side_i  (sdp_q),
    .valid_o (vd),
    .quo_o   (quo),
    .side_o  (sdd)
  );

  // sign restore, zero vector forced to zero
  logic              vo_q;
  logic [2:0][F+1:0] vec_q;
  logic              ok_q;
  logic [SW-1:0]     sdo_q;
  logic [2:0]        sgn;
  logic              nz;

  assign sgn = sdd[DSW-1 -: 3];
  assign nz  = sdd[SW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        if (!nz) begin
          vec_q[j] <= '0;
        end else if (sgn[j]) begin
          vec_q[j] <= -{1'b0, quo[j]};
        end else begin
          vec_q[j] <= {1'b0, quo[j]};
        end
      end
      ok_q  <= nz;
      sdo_q <= sdd[SW-1:0];
    end
  end

  assign valid_o = vo_q;
  assign vec_o   = vec_q;
  assign ok_o    = ok_q;
  assign side_o  = sdo_q;

endmodule

### sv/look_at_camera_basis_core.sv
// look_at_camera_basis_core: top level of the look-at camera basis pipeline
// depends on lacb_norm, lacb_cross (and through them lacb_pkg, lacb_sqrt, lacb_div)
//
// usage:
//   input channel valid_i / stall_o carries one word: camera position, target
//   and up vector, each component signed Q16.16. output channel valid_o /
//   stall_i carries one word: right, upward and forward axes in signed
//   Q1.FRAC_BITS plus the degenerate flag. a word moves when valid is high and
//   stall is low.
//   throughput: one word per cycle while stall_o is low. the delay from input
//   acceptance to valid_o is set mainly by the two length square roots (31
//   one-bit stages each) and the two dividers (FRAC_BITS+1 one-bit stages
//   each).
//   the whole pipeline moves together; when the receiver stalls, the next
//   finished word parks in a skid register and stall_o rises only while that
//   skid register is full, so nothing is lost or repeated.
//   reset clears all valid bits and the output and skid full flags; no clearing
//   pass is needed and words are taken right after reset.
module look_at_camera_basis_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic [31:0]            pos_x_i,
  input  logic [31:0]            pos_y_i,
  input  logic [31:0]            pos_z_i,
  input  logic [31:0]            target_x_i,
  input  logic [31:0]            target_y_i,
  input  logic [31:0]            target_z_i,
  input  logic [31:0]            up_x_i,
  input  logic [31:0]            up_y_i,
  input  logic [31:0]            up_z_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic [FRAC_BITS+1:0]   right_x_o,
  output logic [FRAC_BITS+1:0]   right_y_o,
  output logic [FRAC_BITS+1:0]   right_z_o,
  output logic [FRAC_BITS+1:0]   upward_x_o,
  output logic [FRAC_BITS+1:0]   upward_y_o,
  output logic [FRAC_BITS+1:0]   upward_z_o,
  output logic [FRAC_BITS+1:0]   forward_x_o,
  output logic [FRAC_BITS+1:0]   forward_y_o,
  output logic [FRAC_BITS+1:0]   forward_z_o,
  output logic                   degenerate_o
);

  localparam int F     = FRAC_BITS;
  localparam int OW    = F + 2;
  localparam int IW2   = 32 + OW + 1;
  localparam int CW2   = 2 * OW + 1;
  localparam int S1W   = 3 * OW + 1;
  localparam int S2W   = 6 * OW + 1;
  localparam int OUT_W = 9 * OW + 1;

  logic en;
  logic skid_full_q;

  // whole pipeline advances unless the skid register holds a word
  assign en      = !skid_full_q;
  assign stall_o = skid_full_q;

  // input stage: exact difference target minus position
  logic               vin_q;
  logic [2:0][32:0]   dif_q;
  logic [2:0][31:0]   up_q;
  logic [2:0][31:0]   pos_v, tgt_v, up_v;

  assign pos_v = {pos_z_i, pos_y_i, pos_x_i};
  assign tgt_v = {target_z_i, target_y_i, target_x_i};
  assign up_v  = {up_z_i, up_y_i, up_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q <= 1'b0;
    end else if (en) begin
      vin_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dif_q[j] <= {tgt_v[j][31], tgt_v[j]} - {pos_v[j][31], pos_v[j]};
      end
      up_q <= up_v;
    end
  end

  // forward axis
  logic             vf;
  logic [2:0][OW-1:0] fw;
  logic             okf;
  logic [2:0][31:0] up_f;

  lacb_norm #(.IW(33), .F(F), .SW(96)) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vin_q),
    .vec_i   (dif_q),
    .side_i  (up_q),
    .valid_o (vf),
    .vec_o   (fw),
    .ok_o    (okf),
    .side_o  (up_f)
  );

  // unnormalized right = up x forward
  logic              vr;
  logic [2:0][IW2-1:0] rr;
  logic [S1W-1:0]    sr;

  lacb_cross #(.AW(32), .BW(OW), .SW(S1W)) u_cross_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf),
    .a_i     (up_f),
    .b_i     (fw),
    .side_i  ({fw, okf}),
    .valid_o (vr),
    .c_o     (rr),
    .side_o  (sr)
  );

  // right axis
  logic               vn;
  logic [2:0][OW-1:0] rt;
  logic               okr;
  logic [S1W-1:0]     sn;

  lacb_norm #(.IW(IW2), .F(F), .SW(S1W)) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vr),
    .vec_i   (rr),
    .side_i  (sr),
    .valid_o (vn),
    .vec_o   (rt),
    .ok_o    (okr),
    .side_o  (sn)
  );

  // recomputed up = forward x right
  logic               vu;
  logic [2:0][CW2-1:0] uc;
  logic [S2W-1:0]     su;
  logic [2:0][OW-1:0] fw_n;

  assign fw_n = sn[S1W-1:1];

  lacb_cross #(.AW(OW), .BW(OW), .SW(S2W)) u_cross_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vn),
    .a_i     (fw_n),
    .b_i     (rt),
    .side_i  ({rt, fw_n, sn[0] & okr}),
    .valid_o (vu),
    .c_o     (uc),
    .side_o  (su)
  );

  // round half away from zero to F fraction bits, saturate to one
  logic               vrd_q;
  logic [OUT_W-1:0]   word_q;
  logic [2:0][OW-1:0] uw;

  for (genvar j = 0; j < 3; j++) begin : g_round
    logic [CW2-1:0] mg;
    logic [CW2:0]   rs;
    logic [CW2:0]   mr;
    logic [OW-1:0]  sat;

    assign mg  = uc[j][CW2-1] ? CW2'(-uc[j]) : uc[j];
    assign rs  = {1'b0, mg} + ((CW2 + 1)'(1) << (F - 1));
    assign mr  = rs >> F;
    assign sat = (mr > ((CW2 + 1)'(1) << F)) ? (OW'(1) << F) : mr[OW-1:0];
    assign uw[j] = uc[j][CW2-1] ? OW'(-sat) : sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vrd_q <= 1'b0;
    end else if (en) begin
      vrd_q <= vu;
    end
  end

  // word layout: {degenerate, forward, upward, right}
  always_ff @(posedge clk_i) begin
    if (en) begin
      word_q <= {!su[0], su[3*OW:1], uw, su[S2W-1:3*OW+1]};
    end
  end

  // output register and skid register
  logic             out_vld_q;
  logic [OUT_W-1:0] out_q;
  logic [OUT_W-1:0] skid_q;
  logic             take;

  assign take = out_vld_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (en && vrd_q) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_full_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_full_q) begin
        skid_full_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vrd_q) begin
      if (!out_vld_q || take) begin
        out_q <= word_q;
      end else begin
        skid_q <= word_q;
      end
    end else if (take && skid_full_q) begin
      out_q <= skid_q;
    end
  end

  assign valid_o      = out_vld_q;
  assign right_x_o    = out_q[0*OW +: OW];
  assign right_y_o    = out_q[1*OW +: OW];
  assign right_z_o    = out_q[2*OW +: OW];
  assign upward_x_o   = out_q[3*OW +: OW];
  assign upward_y_o   = out_q[4*OW +: OW];
  assign upward_z_o   = out_q[5*OW +: OW];
  assign forward_x_o  = out_q[6*OW +: OW];
  assign forward_y_o  = out_q[7*OW +: OW];
  assign forward_z_o  = out_q[8*OW +: OW];
  assign degenerate_o = out_q[9*OW];

endmodule
